>>> rtl/lms_sinusoid_amplitude_estimator_macros.svh
// Assertion macros shared by the checker of the amplitude estimator.
`ifndef LMS_SINUSOID_AMPLITUDE_ESTIMATOR_MACROS_SVH
`define LMS_SINUSOID_AMPLITUDE_ESTIMATOR_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define LSAE_ASSERT_SAME(lbl, ant, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ant) |-> (cons)) \
		else $error("lsae assertion failed");

// Antecedent implies consequent in the next cycle.
`define LSAE_ASSERT_NEXT(lbl, ant, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ant) |=> (cons)) \
		else $error("lsae assertion failed");

`endif

>>> rtl/lsae_pkg.sv
// Package with shared types, constants and the sine table function of the estimator.
`default_nettype none
package lsae_pkg;

	localparam int PHASE_BITS_DEF      = 32;
	localparam int SINE_TABLE_BITS_DEF = 10;
	localparam int SAMPLE_BITS_DEF     = 16;

	localparam int CFG_DATA_W  = 32;
	localparam int CFG_INDEX_W = 2;
	localparam int MU_W        = 16;
	localparam int WEIGHT_W    = 32;
	localparam int AMP_W       = 32;
	localparam int TRIG_W      = 16;
	localparam int SQRT_CNT_W  = 5;

	localparam logic [63:0] POLY_A = 64'd1686629713;
	localparam logic [63:0] POLY_B = 64'd688904866;
	localparam logic [63:0] POLY_C = 64'd76016977;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_PHASE_INC = 2'd0,
		REG_MU_OFFSET = 2'd1,
		REG_MU_SINE   = 2'd2,
		REG_MU_COSINE = 2'd3
	} reg_idx_t;

	typedef enum logic [4:0] {
		OP_NONE, OP_LOAD, OP_ROMS, OP_ROMC, OP_MSW1, OP_MCW2, OP_ACCE, OP_MMUE,
		OP_MSE, OP_MCE, OP_MMUS, OP_MMUC, OP_UPD, OP_SQ1L, OP_SQ1H, OP_SQ2L,
		OP_SQ2H, OP_SQEND, OP_SQRT, OP_OUT
	} op_t;

	typedef struct packed {
		op_t                   op;
		logic [SQRT_CNT_W-1:0] sqrt_i;
	} cmd_t;

	typedef struct packed {
		logic out_free;
	} sts_t;

	// Quarter-wave sine magnitude in Q1.15 for quarter position r of 2^qbits.
	function automatic logic [TRIG_W-1:0] quarter_sine(input int unsigned r,
		input int unsigned qbits);
		logic [63:0] x, x2, t, y;
		x  = 64'(r) << (16 - qbits);
		x2 = (x * x) >> 16;
		t  = POLY_B - ((POLY_C * x2) >> 16);
		t  = POLY_A - ((t * x2) >> 16);
		y  = (t * x) >> 16;
		y  = (y + 64'd16384) >> 15;
		if (y > 64'd32767) begin
			y = 64'd32767;
		end
		return y[TRIG_W-1:0];
	endfunction

endpackage
`default_nettype wire

>>> rtl/lsae_ctrl.sv
// Controller state machine that sequences the estimator datapath.
`default_nettype none
module lsae_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	input  lsae_pkg::sts_t     sts,
	output lsae_pkg::cmd_t     cmd
);
	import lsae_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_RUN  = 4'b0010,
		ST_SQRT = 4'b0100,
		ST_DONE = 4'b1000
	} state_t;

	state_t                state_q;
	logic [3:0]            step_q;
	logic [SQRT_CNT_W-1:0] cnt_q;
	op_t                   run_op;

	always_comb begin
		unique case (step_q)
			4'd0:    run_op = OP_ROMS;
			4'd1:    run_op = OP_ROMC;
			4'd2:    run_op = OP_MSW1;
			4'd3:    run_op = OP_MCW2;
			4'd4:    run_op = OP_ACCE;
			4'd5:    run_op = OP_MMUE;
			4'd6:    run_op = OP_MSE;
			4'd7:    run_op = OP_MCE;
			4'd8:    run_op = OP_MMUS;
			4'd9:    run_op = OP_MMUC;
			4'd10:   run_op = OP_UPD;
			4'd11:   run_op = OP_SQ1L;
			4'd12:   run_op = OP_SQ1H;
			4'd13:   run_op = OP_SQ2L;
			4'd14:   run_op = OP_SQ2H;
			default: run_op = OP_SQEND;
		endcase
	end

	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		cmd.sqrt_i = cnt_q;
		unique case (state_q)
			ST_IDLE: cmd.op = in_valid ? OP_LOAD : OP_NONE;
			ST_RUN:  cmd.op = run_op;
			ST_SQRT: cmd.op = OP_SQRT;
			ST_DONE: cmd.op = sts.out_free ? OP_OUT : OP_NONE;
			default: cmd.op = OP_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					step_q <= '0;
					cnt_q  <= '0;
					if (in_valid) begin
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					step_q <= step_q + 4'd1;
					if (step_q == 4'd15) begin
						state_q <= ST_SQRT;
					end
				end
				ST_SQRT: begin
					cnt_q <= cnt_q + SQRT_CNT_W'(1);
					if (cnt_q == '1) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (sts.out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

>>> rtl/lsae_datapath.sv
// Datapath of the estimator: registers, sine table, shared multiplier and root unit.
`default_nettype none
module lsae_datapath #(
	parameter int PHASE_BITS      = lsae_pkg::PHASE_BITS_DEF,
	parameter int SINE_TABLE_BITS = lsae_pkg::SINE_TABLE_BITS_DEF,
	parameter int SAMPLE_BITS     = lsae_pkg::SAMPLE_BITS_DEF
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               cfg_we,
	input  wire logic [lsae_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  wire logic [lsae_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  wire logic signed [SAMPLE_BITS-1:0]      sample,
	input  lsae_pkg::cmd_t                          cmd,
	output lsae_pkg::sts_t                          sts,
	output logic                                    out_valid,
	input  wire logic                               out_ready,
	output logic [lsae_pkg::AMP_W-1:0]              amplitude,
	output logic signed [lsae_pkg::WEIGHT_W-1:0]    offset_weight,
	output logic signed [lsae_pkg::WEIGHT_W-1:0]    sine_weight,
	output logic signed [lsae_pkg::WEIGHT_W-1:0]    cosine_weight
);
	import lsae_pkg::*;

	localparam int QBITS   = SINE_TABLE_BITS - 2;
	localparam int QDEPTH  = (2 ** QBITS) + 1;
	localparam int ADDR_W  = QBITS + 1;
	localparam int ERR_W   = ((SAMPLE_BITS + 12 > 33) ? SAMPLE_BITS + 12 : 33) + 2;
	localparam int MA_W    = 18;
	localparam int PROD_W  = MA_W + ERR_W;
	localparam int ACC_W   = 65;
	localparam logic signed [PROD_W-1:0] WMAX = PROD_W'(64'sd2147483647);
	localparam logic signed [PROD_W-1:0] WMIN = -WMAX - PROD_W'(1);

	logic [PHASE_BITS-1:0]         phase_inc_q, phase_q;
	logic [MU_W-1:0]               mu_o_q, mu_s_q, mu_c_q;
	logic signed [SAMPLE_BITS-1:0] smp_q;
	logic signed [TRIG_W-1:0]      s_q, c_q;
	logic signed [WEIGHT_W-1:0]    w0_q, w1_q, w2_q, w0n_q, w1n_q;
	logic signed [ERR_W-1:0]       err_q, g_q;
	logic signed [PROD_W-1:0]      prod_q;
	logic signed [ACC_W-1:0]       acc_q;
	logic [63:0]                   res_q;
	logic                          out_valid_q;

	logic [TRIG_W-1:0]             rom_mag [QDEPTH];
	logic [SINE_TABLE_BITS-1:0]    k_sel;
	logic [ADDR_W-1:0]             rom_addr;
	logic signed [TRIG_W-1:0]      mag_s, trig;
	logic signed [MA_W-1:0]        mul_a;
	logic signed [ERR_W-1:0]       mul_b;
	logic [63:0]                   rem, bitv;
	logic [64:0]                   trial;
	logic signed [PROD_W-1:0]      w2_next;

	for (genvar k = 0; k < QDEPTH; k++) begin : g_rom
		assign rom_mag[k] = quarter_sine(k, QBITS);
	end

	function automatic logic signed [WEIGHT_W-1:0] sat32(input logic signed [PROD_W-1:0] v);
		if (v > WMAX) begin
			return 32'sh7FFFFFFF;
		end else if (v < WMIN) begin
			return 32'sh80000000;
		end
		return v[WEIGHT_W-1:0];
	endfunction

	always_comb begin
		k_sel = phase_q[PHASE_BITS-1 -: SINE_TABLE_BITS];
		if (cmd.op == OP_ROMC) begin
			k_sel = k_sel + SINE_TABLE_BITS'(2 ** QBITS);
		end
		if (k_sel[QBITS]) begin
			rom_addr = ADDR_W'(2 ** QBITS) - {1'b0, k_sel[QBITS-1:0]};
		end else begin
			rom_addr = {1'b0, k_sel[QBITS-1:0]};
		end
		mag_s = $signed(rom_mag[rom_addr]);
		trig  = k_sel[SINE_TABLE_BITS-1] ? -mag_s : mag_s;
	end

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (cmd.op)
			OP_MSW1: begin mul_a = MA_W'(s_q);                mul_b = ERR_W'(w1_q); end
			OP_MCW2: begin mul_a = MA_W'(c_q);                mul_b = ERR_W'(w2_q); end
			OP_MMUE: begin mul_a = $signed({2'b00, mu_o_q});  mul_b = err_q;        end
			OP_MSE:  begin mul_a = MA_W'(s_q);                mul_b = err_q;        end
			OP_MCE:  begin mul_a = MA_W'(c_q);                mul_b = err_q;        end
			OP_MMUS: begin mul_a = $signed({2'b00, mu_s_q});  mul_b = g_q;          end
			OP_MMUC: begin mul_a = $signed({2'b00, mu_c_q});  mul_b = g_q;          end
			OP_SQ1L: begin mul_a = $signed({2'b00, w1_q[15:0]}); mul_b = ERR_W'(w1_q); end
			OP_SQ1H: begin
				mul_a = MA_W'($signed(w1_q[31:16]));
				mul_b = ERR_W'(w1_q);
			end
			OP_SQ2L: begin mul_a = $signed({2'b00, w2_q[15:0]}); mul_b = ERR_W'(w2_q); end
			OP_SQ2H: begin
				mul_a = MA_W'($signed(w2_q[31:16]));
				mul_b = ERR_W'(w2_q);
			end
			default: begin mul_a = '0;                        mul_b = '0;           end
		endcase
	end

	always_comb begin
		rem     = acc_q[63:0];
		bitv    = 64'd1 << (6'd62 - {cmd.sqrt_i, 1'b0});
		trial   = {1'b0, res_q} + {1'b0, bitv};
		w2_next = PROD_W'(w2_q) - (prod_q >>> 16);
	end

	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		unique case (cmd.op)
			OP_LOAD:  smp_q <= sample;
			OP_ROMS:  s_q   <= trig;
			OP_ROMC:  c_q   <= trig;
			OP_MCW2:  err_q <= ERR_W'(w0_q) + ERR_W'(prod_q >>> 15)
				- (ERR_W'(smp_q) <<< 12);
			OP_ACCE:  err_q <= err_q + ERR_W'(prod_q >>> 15);
			OP_MSE:   w0n_q <= sat32(PROD_W'(w0_q) - (prod_q >>> 16));
			OP_MCE:   g_q   <= ERR_W'(prod_q >>> 15);
			OP_MMUS:  g_q   <= ERR_W'(prod_q >>> 15);
			OP_MMUC:  w1n_q <= sat32(PROD_W'(w1_q) - (prod_q >>> 16));
			OP_UPD:   acc_q <= '0;
			OP_SQ1H:  acc_q <= acc_q + ACC_W'(prod_q);
			OP_SQ2L:  acc_q <= acc_q + (ACC_W'(prod_q) <<< 16);
			OP_SQ2H:  acc_q <= acc_q + ACC_W'(prod_q);
			OP_SQEND: begin
				acc_q <= acc_q + (ACC_W'(prod_q) <<< 16);
				res_q <= '0;
			end
			OP_SQRT: begin
				if ({1'b0, rem} >= trial) begin
					acc_q <= $signed({1'b0, rem - trial[63:0]});
					res_q <= (res_q >> 1) + bitv;
				end else begin
					res_q <= res_q >> 1;
				end
			end
			OP_OUT: begin
				amplitude     <= res_q[AMP_W-1:0];
				offset_weight <= w0_q;
				sine_weight   <= w1_q;
				cosine_weight <= w2_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_inc_q <= '0;
			mu_o_q      <= '0;
			mu_s_q      <= '0;
			mu_c_q      <= '0;
			phase_q     <= '0;
			w0_q        <= '0;
			w1_q        <= '0;
			w2_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (reg_idx_t'(cfg_index))
					REG_PHASE_INC: phase_inc_q <= cfg_data[PHASE_BITS-1:0];
					REG_MU_OFFSET: mu_o_q      <= cfg_data[MU_W-1:0];
					REG_MU_SINE:   mu_s_q      <= cfg_data[MU_W-1:0];
					REG_MU_COSINE: mu_c_q      <= cfg_data[MU_W-1:0];
					default: ;
				endcase
			end
			if (cmd.op == OP_LOAD) begin
				phase_q <= phase_q + phase_inc_q;
			end
			if (cmd.op == OP_UPD) begin
				w0_q <= w0n_q;
				w1_q <= w1n_q;
				w2_q <= sat32(w2_next);
			end
			if (cmd.op == OP_OUT) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign sts.out_free = !out_valid_q || out_ready;
endmodule
`default_nettype wire

>>> rtl/lms_sinusoid_amplitude_estimator.sv
// Top level of the LMS sinusoid amplitude estimator.
//
//  Channel  Handshake              Payload
//  in       in_valid / in_ready    sample
//  out      out_valid / out_ready  amplitude, offset_weight, sine_weight, cosine_weight
//  cfg      cfg_we                 cfg_index, cfg_data
//
// After a transaction is accepted, the result is built by sixteen steps that share one
// multiplier, then the bit-serial square root, and is then loaded into the output
// register. The next sample is accepted once the controller is back in idle, after the
// output register is loaded. Only one sample is in work at a time; a result held while
// out_ready is low stalls the input for as long as it waits.
// Reset clears the phase, the weights and the configuration registers at once.
`default_nettype none
module lms_sinusoid_amplitude_estimator #(
	parameter int PHASE_BITS      = lsae_pkg::PHASE_BITS_DEF,
	parameter int SINE_TABLE_BITS = lsae_pkg::SINE_TABLE_BITS_DEF,
	parameter int SAMPLE_BITS     = lsae_pkg::SAMPLE_BITS_DEF
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               cfg_we,
	input  wire logic [lsae_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  wire logic [lsae_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  wire logic                               in_valid,
	output logic                                    in_ready,
	input  wire logic signed [SAMPLE_BITS-1:0]      sample,
	output logic                                    out_valid,
	input  wire logic                               out_ready,
	output logic [lsae_pkg::AMP_W-1:0]              amplitude,
	output logic signed [lsae_pkg::WEIGHT_W-1:0]    offset_weight,
	output logic signed [lsae_pkg::WEIGHT_W-1:0]    sine_weight,
	output logic signed [lsae_pkg::WEIGHT_W-1:0]    cosine_weight
);
	import lsae_pkg::*;

	cmd_t cmd;
	sts_t sts;

	lsae_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	lsae_datapath #(
		.PHASE_BITS      (PHASE_BITS),
		.SINE_TABLE_BITS (SINE_TABLE_BITS),
		.SAMPLE_BITS     (SAMPLE_BITS)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.sample        (sample),
		.cmd           (cmd),
		.sts           (sts),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.amplitude     (amplitude),
		.offset_weight (offset_weight),
		.sine_weight   (sine_weight),
		.cosine_weight (cosine_weight)
	);
endmodule
`default_nettype wire

>>> rtl/lsae_checker.sv
// Port-level checker for the amplitude estimator, bound to the top level.
`default_nettype none
`include "lms_sinusoid_amplitude_estimator_macros.svh"
module lsae_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_ready,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [31:0] amplitude,
	input wire logic [31:0] sine_weight
);
	// A stalled result transaction keeps its valid and payload.
	`LSAE_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(amplitude) && $stable(sine_weight))
	// Only one sample is in work: acceptance makes the block busy.
	`LSAE_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)
	// A new result only appears after the block was busy working on it.
	`LSAE_ASSERT_SAME(a_result_from_work, $rose(out_valid), !$past(in_ready))
endmodule

bind lms_sinusoid_amplitude_estimator lsae_checker u_lsae_checker (.*);
`default_nettype wire
